/* sv/serial_download_responder_defines.svh */
// ----------------------------------------------------------------------------
// Serial download responder assertion macros
// Shorthand for the concurrent checks written at the end of the responder.
// ----------------------------------------------------------------------------
`ifndef SERIAL_DOWNLOAD_RESPONDER_DEFINES_SVH
`define SERIAL_DOWNLOAD_RESPONDER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SDR_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define SDR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/sdr_pkg.sv */
// ----------------------------------------------------------------------------
// Serial download responder package
// Opcodes, status and action codes, register map and defaults.
// ----------------------------------------------------------------------------
package sdr_pkg;

  localparam int SeqBitsDefault   = 16;
  localparam int TimerBitsDefault = 24;

  localparam int MagicBits   = 16;
  localparam int TimeoutBits = 24;
  localparam int AddrBits    = 3;
  localparam int DataBits    = 32;

  localparam logic [TimeoutBits-1:0] TimeoutDefault = TimeoutBits'(8 * 60 * 1000);

  // Register indexes, taken from paddr bit 2.
  localparam logic RegMagic   = 1'b0;
  localparam logic RegTimeout = 1'b1;

  localparam logic [7:0] OpMask    = 8'hF7;
  localparam logic [7:0] OpPing    = 8'h10;
  localparam logic [7:0] OpVersion = 8'h15;
  localparam logic [7:0] OpErase   = 8'h65;
  localparam logic [7:0] OpData    = 8'h45;
  localparam logic [7:0] OpBegin   = 8'h12;
  localparam logic [7:0] OpRemote  = 8'hD2;
  localparam logic [7:0] RunBit    = 8'h02;

  localparam logic [7:0] StatusOk       = 8'd0;
  localparam logic [7:0] StatusNotArmed = 8'd1;
  localparam logic [7:0] StatusBadCheck = 8'd3;

  localparam logic [3:0] LenNone    = 4'd0;
  localparam logic [3:0] LenShort   = 4'd1;
  localparam logic [3:0] LenStatus  = 4'd2;
  localparam logic [3:0] LenMagic   = 4'd3;
  localparam logic [3:0] LenVersion = 4'd9;

  localparam logic [2:0] ActNone    = 3'd0;
  localparam logic [2:0] ActReset   = 3'd1;
  localparam logic [2:0] ActStart   = 3'd2;
  localparam logic [2:0] ActErase   = 3'd3;
  localparam logic [2:0] ActPower   = 3'd4;
  localparam logic [2:0] ActInstall = 3'd5;
  localparam logic [2:0] ActAccept  = 3'd6;

endpackage

/* sv/sdr_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Carries one packet or idle tick word from the host side to the responder.
// ----------------------------------------------------------------------------
interface sdr_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  opcode;
  logic [7:0]  param_low;
  logic [7:0]  param_high;
  logic [7:0]  check_first;
  logic [7:0]  check_second;
  logic        store_full;
  logic [15:0] image_magic;

  modport source (
    output valid, command, opcode, param_low, param_high, check_first,
           check_second, store_full, image_magic,
    input  ready
  );

  modport sink (
    input  valid, command, opcode, param_low, param_high, check_first,
           check_second, store_full, image_magic,
    output ready
  );
endinterface

/* sv/sdr_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Carries one result word from the responder to the reply side.
// ----------------------------------------------------------------------------
interface sdr_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reply_length;
  logic [7:0]  reply_head;
  logic [7:0]  reply_second;
  logic [7:0]  reply_third;
  logic        send_version;
  logic [2:0]  action;
  logic [15:0] progress_index;
  logic        program_present;

  modport source (
    output valid, reply_length, reply_head, reply_second, reply_third,
           send_version, action, progress_index, program_present,
    input  ready
  );

  modport sink (
    input  valid, reply_length, reply_head, reply_second, reply_third,
           send_version, action, progress_index, program_present,
    output ready
  );
endinterface

/* sv/serial_download_responder.sv */
// ----------------------------------------------------------------------------
// Serial download responder
// Decodes host download packets and idle ticks, keeps the session state and
// produces one reply/action word per accepted request word.
// ----------------------------------------------------------------------------
// A request word's result word is registered in the result register, or in the
// skid entry while the consumer stalls, and then shown on the response channel.
// Throughput: one word per cycle while the skid entry is empty, set by the single
// decode stage in front of the result register; a two-entry output buffer (result
// register plus skid) catches one word while the consumer stalls.
// Reset (synchronous, active high) clears the session state, empties the
// output buffer and loads the register defaults; no clearing pass is needed.
`include "serial_download_responder_defines.svh"

module serial_download_responder #(
  parameter int SEQ_BITS   = sdr_pkg::SeqBitsDefault,
  parameter int TIMER_BITS = sdr_pkg::TimerBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  sdr_req_if.sink                       req,
  sdr_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdr_pkg::AddrBits-1:0]  paddr,
  input  logic [sdr_pkg::DataBits-1:0]  pwdata,
  output logic [sdr_pkg::DataBits-1:0]  prdata,
  output logic                          pready
);

  localparam logic [SEQ_BITS-1:0]   SeqOne   = SEQ_BITS'(1);
  localparam logic [TIMER_BITS-1:0] TimerMax = '1;

  // One result word as it sits in the output buffer.
  typedef struct packed {
    logic [3:0]  reply_length;
    logic [7:0]  reply_head;
    logic [7:0]  reply_second;
    logic [7:0]  reply_third;
    logic        send_version;
    logic [2:0]  action;
    logic [15:0] progress_index;
    logic        program_present;
  } result_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. The APB port never waits; a write lands on the
  // access cycle and reads return the current value.
  // ---------------------------------------------------------------------------
  logic [sdr_pkg::MagicBits-1:0]   expected_magic;
  logic [sdr_pkg::TimeoutBits-1:0] timeout_ticks;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= '0;
      timeout_ticks  <= sdr_pkg::TimeoutDefault;
    end else if (cfg_write) begin
      unique case (paddr[2])
        sdr_pkg::RegMagic:   expected_magic <= pwdata[sdr_pkg::MagicBits-1:0];
        sdr_pkg::RegTimeout: timeout_ticks  <= pwdata[sdr_pkg::TimeoutBits-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sdr_pkg::RegMagic:   prdata = sdr_pkg::DataBits'(expected_magic);
      sdr_pkg::RegTimeout: prdata = sdr_pkg::DataBits'(timeout_ticks);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Session state.
  // ---------------------------------------------------------------------------
  logic                  armed, armed_next;
  logic [7:0]            previous_opcode, previous_opcode_next;
  logic [SEQ_BITS-1:0]   expected_index, expected_index_next;
  logic                  image_held, image_held_next;
  logic [TIMER_BITS-1:0] idle_count, idle_count_next;

  // ---------------------------------------------------------------------------
  // Output buffer: the result register feeds the response channel, and the
  // skid entry catches one word accepted while the consumer stalls. Intake
  // stops only while the skid entry is occupied.
  // ---------------------------------------------------------------------------
  result_t out_word, skid_word, res;
  logic    out_valid, skid_valid;
  logic    in_fire, out_fire;

  assign req.ready = !skid_valid;
  assign in_fire   = req.valid && req.ready;
  assign out_fire  = out_valid && rsp.ready;

  // ---------------------------------------------------------------------------
  // Decode of one request word against the current session state. All of it
  // is a handful of byte compares, a SEQ_BITS-bit increment and a timer increment.
  // ---------------------------------------------------------------------------
  logic [7:0]            op_inv;
  logic [SEQ_BITS-1:0]   seq;
  logic [7:0]            status;
  logic [TIMER_BITS-1:0] idle_inc;

  always_comb begin
    op_inv   = ~req.opcode;
    seq      = SEQ_BITS'({req.param_high, req.param_low});
    status   = (req.check_first != req.check_second) ? sdr_pkg::StatusBadCheck :
               (armed ? sdr_pkg::StatusOk : sdr_pkg::StatusNotArmed);
    idle_inc = (idle_count == TimerMax) ? idle_count : idle_count + TIMER_BITS'(1);

    armed_next           = armed;
    previous_opcode_next = previous_opcode;
    expected_index_next  = expected_index;
    image_held_next      = image_held;
    idle_count_next      = idle_count;

    res              = '0;
    res.reply_length = sdr_pkg::LenNone;
    res.action       = sdr_pkg::ActNone;

    if (req.command) begin
      // Idle tick: count up, saturating, and request power off on timeout
      // or on saturation of the counter.
      idle_count_next = idle_inc;
      if ((32'(idle_inc) >= 32'(timeout_ticks)) || (idle_inc == TimerMax)) begin
        res.action          = sdr_pkg::ActPower;
        armed_next          = 1'b0;
        expected_index_next = SeqOne;
        idle_count_next     = '0;
      end
    end else begin
      unique case (req.opcode & sdr_pkg::OpMask)
        sdr_pkg::OpPing: begin
          res.reply_length = sdr_pkg::LenShort;
          res.reply_head   = op_inv;
        end
        sdr_pkg::OpVersion: begin
          res.reply_length = sdr_pkg::LenVersion;
          res.reply_head   = op_inv;
          res.send_version = 1'b1;
        end
        sdr_pkg::OpErase: begin
          res.reply_length = sdr_pkg::LenShort;
          res.reply_head   = op_inv;
          res.action       = sdr_pkg::ActErase;
        end
        sdr_pkg::OpData: begin
          res.reply_length = sdr_pkg::LenStatus;
          res.reply_head   = op_inv;
          res.reply_second = status;
          if (status != sdr_pkg::StatusOk) begin
            res.action          = sdr_pkg::ActReset;
            armed_next          = 1'b0;
            expected_index_next = SeqOne;
            idle_count_next     = '0;
          end else if (previous_opcode != op_inv) begin
            // A packet whose toggle bit repeats the last one is acknowledged
            // and otherwise ignored; this branch handles a fresh packet.
            previous_opcode_next = op_inv;
            if ((expected_index != SeqOne) && (seq == '0)) begin
              // Sequence zero closes the image; keep it only if its magic
              // matches.
              if (req.image_magic == expected_magic) begin
                image_held_next = 1'b1;
                res.action      = sdr_pkg::ActInstall;
              end else begin
                res.action = sdr_pkg::ActReset;
              end
              armed_next          = 1'b0;
              expected_index_next = SeqOne;
              idle_count_next     = '0;
            end else if (req.store_full || (seq != expected_index)) begin
              res.action          = sdr_pkg::ActReset;
              armed_next          = 1'b0;
              expected_index_next = SeqOne;
              idle_count_next     = '0;
            end else begin
              expected_index_next = expected_index + SeqOne;
              res.action          = sdr_pkg::ActAccept;
            end
          end
        end
        sdr_pkg::OpBegin: begin
          previous_opcode_next = req.opcode;
          expected_index_next  = SeqOne;
          idle_count_next      = '0;
          if (armed) begin
            // A second begin inside a session drops it without a reply.
            res.action = sdr_pkg::ActReset;
            armed_next = 1'b0;
          end else begin
            res.reply_length = sdr_pkg::LenMagic;
            res.reply_head   = op_inv;
            res.reply_second = expected_magic[15:8];
            res.reply_third  = expected_magic[7:0];
            armed_next       = 1'b1;
            image_held_next  = 1'b0;
          end
        end
        sdr_pkg::OpRemote: begin
          armed_next          = 1'b0;
          expected_index_next = SeqOne;
          idle_count_next     = '0;
          if (((req.param_low & sdr_pkg::RunBit) != 8'd0) && image_held) begin
            res.action = sdr_pkg::ActStart;
          end else begin
            res.action = sdr_pkg::ActReset;
          end
        end
        default: begin
          // Unknown request: drop the session, send nothing.
          res.action          = sdr_pkg::ActReset;
          armed_next          = 1'b0;
          expected_index_next = SeqOne;
          idle_count_next     = '0;
        end
      endcase
    end

    res.progress_index  = 16'(expected_index_next);
    res.program_present = image_held_next;
  end

  // State moves only with an accepted request word.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      previous_opcode <= '0;
      expected_index  <= SeqOne;
      image_held      <= 1'b0;
      idle_count      <= '0;
    end else if (in_fire) begin
      armed           <= armed_next;
      previous_opcode <= previous_opcode_next;
      expected_index  <= expected_index_next;
      image_held      <= image_held_next;
      idle_count      <= idle_count_next;
    end
  end

  // Output buffer control. When the result register frees up, the skid word
  // moves forward first; a new word can only arrive while the skid is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
        if (in_fire) begin
          out_word <= res;
        end
      end
    end else if (in_fire) begin
      skid_word  <= res;
      skid_valid <= 1'b1;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.reply_length    = out_word.reply_length;
  assign rsp.reply_head      = out_word.reply_head;
  assign rsp.reply_second    = out_word.reply_second;
  assign rsp.reply_third     = out_word.reply_third;
  assign rsp.send_version    = out_word.send_version;
  assign rsp.action          = out_word.action;
  assign rsp.progress_index  = out_word.progress_index;
  assign rsp.program_present = out_word.program_present;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `SDR_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid, "skid word without result word")
  `SDR_ASSERT_NEXT(a_stall_fills_skid, in_fire && out_valid && !rsp.ready, skid_valid, "stalled word lost")
  `SDR_ASSERT_NEXT(a_drain_empties, out_fire && !skid_valid && !in_fire, !out_valid, "result word repeated")
  `SDR_ASSERT_NEXT(a_install_holds, in_fire && (res.action == sdr_pkg::ActInstall), image_held, "installed image not held")

endmodule
